FILE: src/bwu_pkg.sv
// types and constants shared by the trap table modules
// no dependencies
`timescale 1ns / 1ps

package bwu_pkg;

    typedef enum logic [2:0] {
        ACT_SET      = 3'd0,
        ACT_CLR_SLOT = 3'd1,
        ACT_CLR_ADDR = 3'd2,
        ACT_CLR_ALL  = 3'd3,
        ACT_TRACE    = 3'd4,
        ACT_SNOOP    = 3'd5,
        ACT_STEP     = 3'd6,
        ACT_READ     = 3'd7
    } t_action;

    localparam logic [2:0] KIND_BREAK = 3'd0;
    localparam logic [2:0] KIND_TRACE = 3'd1;
    localparam logic [2:0] KIND_TRON  = 3'd2;
    localparam logic [2:0] KIND_TROFF = 3'd3;
    localparam logic [2:0] KIND_ONCE  = 3'd4;
    localparam logic [2:0] KIND_WATCH = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [15:0] pc;
        logic        trace_enable;
        logic [7:0]  mem_byte;
        logic [3:0]  slot_index;
        logic        match_any;
        logic [2:0]  trap_kind;
        logic [15:0] trap_address;
        t_action     action;
    } t_req;

    typedef struct packed {
        logic [2:0]  entry_kind;
        logic [15:0] entry_address;
        logic        entry_valid;
        logic        fast_run;
        logic        trace_now;
        logic        watch_hit;
        logic        stop;
        logic [3:0]  slot_out;
        logic [1:0]  status;
    } t_res;

    typedef struct packed {
        logic [15:0] addr;
        logic [2:0]  kind;
        logic [7:0]  data;
    } t_slot;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic bad_idx;
        logic rd_en;
        logic eval_en;
        logic fin;
        logic commit;
    } t_cmd;

endpackage

FILE: src/bwu_obuf.sv
// one-entry output register between the result and the master side
// depends on bwu_pkg
`timescale 1ns / 1ps

module bwu_obuf
    import bwu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_res i_res,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    logic r_full;
    logic n_full;
    t_res r_res;

    assign o_ready = !r_full || i_ready;
    assign o_valid = r_full;
    assign o_res   = r_res;

    always_comb begin
        n_full = r_full;
        if (i_valid && o_ready) begin
            n_full = 1'b1;
        end else if (i_ready) begin
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: src/bwu_ctrl.sv
// sequencer: accepts a request, walks the slots that the action needs, hands off the result
// depends on bwu_pkg
`timescale 1ns / 1ps

module bwu_ctrl
    import bwu_pkg::*;
#(
    parameter int TRAP_SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  t_action                           i_action,
    input  logic [3:0]                        i_slot_index,
    input  logic                              i_out_ready,
    output t_cmd                              o_cmd,
    output logic [((TRAP_SLOTS > 1) ? $clog2(TRAP_SLOTS) : 1)-1:0] o_rd_addr,
    output logic [((TRAP_SLOTS > 1) ? $clog2(TRAP_SLOTS) : 1)-1:0] o_eval_ptr
);

    localparam int PW = (TRAP_SLOTS > 1) ? $clog2(TRAP_SLOTS) : 1;
    localparam logic [PW-1:0] LAST_SLOT = PW'(TRAP_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [PW-1:0] r_last, n_last;
    logic [PW-1:0] r_eval_ptr;
    logic          r_eval_en;
    logic          bad_idx;
    logic          accept;

    assign bad_idx    = int'(i_slot_index) >= TRAP_SLOTS;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign o_rd_addr  = r_ptr;
    assign o_eval_ptr = r_eval_ptr;

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.eval_en = r_eval_en;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    if (i_action inside {ACT_SET, ACT_CLR_ADDR, ACT_SNOOP, ACT_STEP}) begin
                        n_ptr   = '0;
                        n_last  = LAST_SLOT;
                        n_state = S_SCAN;
                    end else if (i_action inside {ACT_CLR_SLOT, ACT_READ}) begin
                        if (bad_idx) begin
                            o_cmd.bad_idx = 1'b1;
                            n_state       = S_FIN;
                        end else begin
                            n_ptr   = PW'(i_slot_index);
                            n_last  = PW'(i_slot_index);
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_ptr == r_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                if (i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_eval_en <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_eval_en <= o_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_last     <= n_last;
        r_eval_ptr <= r_ptr;
    end

`ifndef SYNTHESIS
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_out_ready) |=> (r_state == S_FIN))
        else $error("result dropped while output stalled");
    a_eval_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eval_en |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("slot evaluation outside a scan");
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= r_last))
        else $error("scan pointer passed its end");
`endif

endmodule

FILE: src/bwu_dp.sv
// datapath: slot memory, valid bits, counters, trace mode, result assembly
// depends on bwu_pkg
`timescale 1ns / 1ps

module bwu_dp
    import bwu_pkg::*;
#(
    parameter int TRAP_SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cmd                              i_cmd,
    input  t_req                              i_req,
    input  logic [((TRAP_SLOTS > 1) ? $clog2(TRAP_SLOTS) : 1)-1:0] i_rd_addr,
    input  logic [((TRAP_SLOTS > 1) ? $clog2(TRAP_SLOTS) : 1)-1:0] i_eval_ptr,
    output t_res                              o_res
);

    localparam int PW = (TRAP_SLOTS > 1) ? $clog2(TRAP_SLOTS) : 1;
    localparam int CW = $clog2(TRAP_SLOTS + 1);

    // slot contents, written and read one slot per cycle
    t_slot r_mem [TRAP_SLOTS];
    t_slot r_rd;

    logic [TRAP_SLOTS-1:0] r_valid;
    logic [CW-1:0]         r_used, n_used;
    logic [CW-1:0]         r_watch, n_watch;
    logic                  r_pending, n_pending;
    logic                  r_trace, n_trace;

    // request and per-request accumulators
    t_req        r_req;
    logic [1:0]  r_status, n_status;
    logic        r_found, n_found;
    logic [3:0]  r_slot_out, n_slot_out;
    logic        r_brk, n_brk;
    logic        r_tr, n_tr;
    logic        r_on, n_on;
    logic        r_off, n_off;
    logic        r_ent_vld, n_ent_vld;
    logic [15:0] r_ent_addr, n_ent_addr;
    logic [2:0]  r_ent_kind, n_ent_kind;

    logic        ev_valid;
    logic        v_set, v_clr, v_clr_all;
    logic        do_free;
    logic        mem_we;
    t_slot       mem_wd;
    logic        trace_new;

    assign ev_valid  = r_valid[i_eval_ptr];
    assign trace_new = r_off ? 1'b0 : (r_on ? 1'b1 : r_trace);

    always_comb begin
        n_used     = r_used;
        n_watch    = r_watch;
        n_pending  = r_pending;
        n_trace    = r_trace;
        n_status   = r_status;
        n_found    = r_found;
        n_slot_out = r_slot_out;
        n_brk      = r_brk;
        n_tr       = r_tr;
        n_on       = r_on;
        n_off      = r_off;
        n_ent_vld  = r_ent_vld;
        n_ent_addr = r_ent_addr;
        n_ent_kind = r_ent_kind;
        v_set      = 1'b0;
        v_clr      = 1'b0;
        v_clr_all  = 1'b0;
        do_free    = 1'b0;
        mem_we     = 1'b0;
        mem_wd     = r_rd;

        if (i_cmd.start) begin
            n_status   = i_cmd.bad_idx ? ST_INVALID : ST_OK;
            n_found    = 1'b0;
            n_slot_out = '0;
            n_brk      = 1'b0;
            n_tr       = 1'b0;
            n_on       = 1'b0;
            n_off      = 1'b0;
            n_ent_vld  = 1'b0;
            n_ent_addr = '0;
            n_ent_kind = '0;
        end

        if (i_cmd.eval_en) begin
            case (r_req.action)
                ACT_SET: begin
                    if (!ev_valid && !r_found) begin
                        n_found     = 1'b1;
                        n_slot_out  = 4'(i_eval_ptr);
                        v_set       = 1'b1;
                        mem_we      = 1'b1;
                        mem_wd.addr = r_req.trap_address;
                        mem_wd.kind = r_req.trap_kind;
                        mem_wd.data = r_req.mem_byte;
                        n_used      = r_used + CW'(1);
                        if (r_req.trap_kind == KIND_WATCH) begin
                            n_watch = r_watch + CW'(1);
                        end
                    end
                end
                ACT_CLR_SLOT: begin
                    if (!ev_valid) begin
                        n_status = ST_INVALID;
                    end else begin
                        do_free = 1'b1;
                    end
                end
                ACT_CLR_ADDR: begin
                    if (ev_valid && r_rd.addr == r_req.trap_address &&
                        (r_req.match_any || r_rd.kind == r_req.trap_kind)) begin
                        do_free = 1'b1;
                    end
                end
                ACT_SNOOP: begin
                    if (ev_valid && r_rd.kind == KIND_WATCH &&
                        r_rd.addr == r_req.trap_address && r_rd.data != r_req.mem_byte) begin
                        mem_we      = 1'b1;
                        mem_wd.data = r_req.mem_byte;
                        n_pending   = 1'b1;
                    end
                end
                ACT_STEP: begin
                    if (ev_valid && r_rd.addr == r_req.pc) begin
                        case (r_rd.kind)
                            KIND_BREAK: n_brk = 1'b1;
                            KIND_TRACE: n_tr  = 1'b1;
                            KIND_TRON:  n_on  = 1'b1;
                            KIND_TROFF: n_off = 1'b1;
                            KIND_ONCE: begin
                                n_brk   = 1'b1;
                                do_free = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ACT_READ: begin
                    if (ev_valid) begin
                        n_ent_vld  = 1'b1;
                        n_ent_addr = r_rd.addr;
                        n_ent_kind = r_rd.kind;
                    end
                end
                default: ;
            endcase
        end

        // release one slot: drop the pending watch with the last watchpoint
        if (do_free) begin
            v_clr = 1'b1;
            if (r_rd.kind == KIND_WATCH && r_watch != '0) begin
                n_watch = r_watch - CW'(1);
                if (r_watch == CW'(1)) begin
                    n_pending = 1'b0;
                end
            end
            if (r_used != '0) begin
                n_used = r_used - CW'(1);
            end
        end

        if (i_cmd.commit) begin
            case (r_req.action)
                ACT_CLR_ALL: begin
                    v_clr_all = 1'b1;
                    n_used    = '0;
                    n_watch   = '0;
                    n_pending = 1'b0;
                end
                ACT_TRACE: begin
                    n_trace = r_req.trace_enable;
                end
                ACT_STEP: begin
                    n_pending = 1'b0;
                    n_trace   = trace_new;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_res        = '0;
        o_res.status = r_status;
        case (r_req.action)
            ACT_SET: begin
                if (r_found) begin
                    o_res.slot_out = r_slot_out;
                end else begin
                    o_res.status = ST_FULL;
                end
            end
            ACT_STEP: begin
                o_res.stop      = r_brk || r_pending;
                o_res.watch_hit = r_pending;
                o_res.trace_now = r_tr || trace_new;
                o_res.fast_run  = !trace_new && (r_used == '0);
            end
            ACT_READ: begin
                o_res.entry_valid   = r_ent_vld;
                o_res.entry_address = r_ent_addr;
                o_res.entry_kind    = r_ent_kind;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_used    <= '0;
            r_watch   <= '0;
            r_pending <= 1'b0;
            r_trace   <= 1'b0;
        end else begin
            if (v_clr_all) begin
                r_valid <= '0;
            end else if (v_set) begin
                r_valid[i_eval_ptr] <= 1'b1;
            end else if (v_clr) begin
                r_valid[i_eval_ptr] <= 1'b0;
            end
            r_used    <= n_used;
            r_watch   <= n_watch;
            r_pending <= n_pending;
            r_trace   <= n_trace;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req <= i_req;
        end
        r_status   <= n_status;
        r_found    <= n_found;
        r_slot_out <= n_slot_out;
        r_brk      <= n_brk;
        r_tr       <= n_tr;
        r_on       <= n_on;
        r_off      <= n_off;
        r_ent_vld  <= n_ent_vld;
        r_ent_addr <= n_ent_addr;
        r_ent_kind <= n_ent_kind;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_eval_ptr] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_watch_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_watch <= r_used)
        else $error("more watchpoints than used slots");
    a_pending_needs_watch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_watch != '0))
        else $error("watch change pending with no watchpoint");
`endif

endmodule

FILE: src/breakpoint_watchpoint_unit.sv
// top level of the debug trap table: stream ports, sequencer, datapath, output register
// depends on bwu_pkg, bwu_ctrl, bwu_dp, bwu_obuf
`timescale 1ns / 1ps

// Debug trap table for a 16-bit CPU. Each request carries one action (set a trap in
// the lowest free slot, clear a slot, clear by address, clear all, set trace mode,
// snoop a memory write, end an instruction, read a slot) and yields exactly one
// result. The slot contents live in a memory read one slot per cycle, so set,
// clear by address, write snoop and step end walk every slot; clear slot and read
// slot read only the indexed slot; clear all, trace mode and an out-of-range slot
// index read no slot. One request is worked on at a time: s_axis_tready is high
// only while the sequencer is idle. Results go through a one-entry output
// register, so a stalled m_axis side does not hold up the next request until its
// result is due. Valid bits and counters are cleared by reset; slot memory is not,
// and a free slot always reads back as zero address and kind.

module breakpoint_watchpoint_unit
    import bwu_pkg::*;
#(
    parameter int TRAP_SLOTS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] action, [18:3] trap_address, [21:19] trap_kind, [22] match_any,
    // [26:23] slot_index, [34:27] mem_byte, [35] trace_enable, [51:36] pc, rest zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] status, [5:2] slot_out, [6] stop, [7] watch_hit, [8] trace_now,
    // [9] fast_run, [10] entry_valid, [26:11] entry_address, [29:27] entry_kind, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int PW = (TRAP_SLOTS > 1) ? $clog2(TRAP_SLOTS) : 1;

    t_req          req;
    t_cmd          cmd;
    t_res          dp_res;
    t_res          out_res;
    logic          obuf_ready;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] eval_ptr;

    // unused pad bits of the input word are ignored
    assign req = t_req'(s_axis_tdata[$bits(t_req)-1:0]);
    assign m_axis_tdata = {{(OUT_TDATA_W - $bits(t_res)){1'b0}}, out_res};

    bwu_ctrl #(
        .TRAP_SLOTS (TRAP_SLOTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_action     (req.action),
        .i_slot_index (req.slot_index),
        .i_out_ready  (obuf_ready),
        .o_cmd        (cmd),
        .o_rd_addr    (rd_addr),
        .o_eval_ptr   (eval_ptr)
    );

    bwu_dp #(
        .TRAP_SLOTS (TRAP_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req      (req),
        .i_rd_addr  (rd_addr),
        .i_eval_ptr (eval_ptr),
        .o_res      (dp_res)
    );

    bwu_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cmd.fin),
        .o_ready (obuf_ready),
        .i_res   (dp_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

endmodule
